FILE: design/ppm_pkg.sv
package ppm_pkg;

  // Field width and internal word widths.
  localparam int DW = 32;
  // Squared norm, dot product and divider remainder.
  localparam int SW = 64;
  // Dividend width: a 64-bit product times a 32-bit magnitude.
  localparam int NW = 96;
  // Quotient bits produced by the divider.
  localparam int QW = 34;
  // Divider lanes: three matrix columns and the translation.
  localparam int NLANE = 4;
  localparam int OFF_LANE = 3;

  localparam logic [1:0] LAST_ROW = 2'd2;

  typedef logic [DW-1:0] word_t;

  // Per-row information that travels beside the divider.
  typedef struct packed {
    logic [1:0] row;
    logic       last;
    logic       zero;
    logic [2:0] ent_neg;
    logic       off_neg;
    word_t      pt;
  } side_t;

endpackage

FILE: design/plane_projection_matrix.sv
// Channel   Signals                                     Handshake
// command   start, busy, point_*, normal_*              taken when start && !busy
// result    done, row_index, col0..col2, offset,        done marks each row
//           last_row, zero_normal
//
// Each plane produces three result rows, one per cycle; the row sequencer at the
// input holds off a new plane until the plane before it is issuing its last row.
// A row passes through six arithmetic stages, a 34-stage shared-divisor divider
// and two rounding/formatting stages.
// Reset (rst, synchronous) clears the sequencer and all valid bits.
// The result side never stalls, so the pipeline always advances.
module plane_projection_matrix import ppm_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] point_x,
  input  logic signed [31:0] point_y,
  input  logic signed [31:0] point_z,
  input  logic signed [31:0] normal_x,
  input  logic signed [31:0] normal_y,
  input  logic signed [31:0] normal_z,
  output logic               done,
  output logic [1:0]         row_index,
  output logic signed [31:0] col0,
  output logic signed [31:0] col1,
  output logic signed [31:0] col2,
  output logic signed [31:0] offset,
  output logic               last_row,
  output logic               zero_normal
);

  // The plane of the current transaction is held while its three rows are issued.
  logic               accept;
  logic               issue_valid;
  logic [1:0]         issue_row;
  logic [2:0][DW-1:0] pt_hold;
  logic [2:0][DW-1:0] nm_hold;

  // The next plane may be taken in the cycle that issues the last row.
  assign busy   = issue_valid && (issue_row != LAST_ROW);
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      issue_valid <= 1'b0;
      issue_row   <= '0;
    end else if (accept) begin
      issue_valid <= 1'b1;
      issue_row   <= '0;
    end else if (issue_valid) begin
      if (issue_row == LAST_ROW) begin
        issue_valid <= 1'b0;
      end else begin
        issue_row <= issue_row + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pt_hold <= {point_z, point_y, point_x};
      nm_hold <= {normal_z, normal_y, normal_x};
    end
  end

  logic                     f_valid;
  logic [SW-1:0]            f_s;
  logic [NLANE-1:0][NW-1:0] f_num;
  side_t                    f_side;

  ppm_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (issue_valid),
    .row       (issue_row),
    .point     (pt_hold),
    .normal    (nm_hold),
    .out_valid (f_valid),
    .s         (f_s),
    .num       (f_num),
    .side      (f_side)
  );

  logic                     d_valid;
  logic [SW-1:0]            d_s;
  logic [NLANE-1:0][QW-1:0] d_quo;
  logic [NLANE-1:0][SW-1:0] d_rem;
  side_t                    d_side;

  ppm_div u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (f_valid),
    .s_in      (f_s),
    .num       (f_num),
    .side_in   (f_side),
    .out_valid (d_valid),
    .s_out     (d_s),
    .quo       (d_quo),
    .rem       (d_rem),
    .side_out  (d_side)
  );

  ppm_out #(.FRAC_BITS(FRAC_BITS)) u_out (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (d_valid),
    .s           (d_s),
    .quo         (d_quo),
    .rem         (d_rem),
    .side        (d_side),
    .done        (done),
    .row_index   (row_index),
    .col0        (col0),
    .col1        (col1),
    .col2        (col2),
    .offset      (offset),
    .last_row    (last_row),
    .zero_normal (zero_normal)
  );

  // An accepted transaction keeps the command side busy in the next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> busy)
    else $error("busy not raised after an accepted transaction");

  // The last row flag marks row two and nothing else.
  a_last_row: assert property (@(posedge clk) disable iff (rst)
    done |-> (last_row == (row_index == LAST_ROW)))
    else $error("last_row disagrees with row_index");

  // Rows of one plane leave in consecutive cycles and in order.
  a_row_order: assert property (@(posedge clk) disable iff (rst)
    done && !last_row |=> done && (row_index == $past(row_index) + 2'd1))
    else $error("result rows out of order or split");

  // All rows of one plane agree on the zero-normal flag.
  a_zero_flag: assert property (@(posedge clk) disable iff (rst)
    done && !last_row |=> zero_normal == $past(zero_normal))
    else $error("zero_normal changed within one plane");

endmodule

FILE: design/ppm_front.sv
module ppm_front import ppm_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  input  logic [1:0]                row,
  input  logic [2:0][DW-1:0]        point,
  input  logic [2:0][DW-1:0]        normal,
  output logic                      out_valid,
  output logic [SW-1:0]             s,
  output logic [NLANE-1:0][NW-1:0]  num,
  output side_t                     side
);

  function automatic logic [DW-1:0] mag_of(input logic [DW-1:0] x);
    return x[DW-1] ? (~x + 1'b1) : x;
  endfunction

  // Stage 1: magnitudes and signs.
  logic                 v1;
  logic [1:0]           row1;
  logic [2:0][DW-1:0]   nmag1;
  logic [2:0][DW-1:0]   pmag1;
  logic [2:0]           nneg1;
  logic [2:0]           pneg1;
  word_t                pt1;

  // Stage 2: products.
  logic                 v2;
  logic [1:0]           row2;
  logic [2:0][SW-1:0]   sq2;
  logic [2:0][SW-1:0]   dp2;
  logic [2:0]           dpn2;
  logic [2:0][SW-1:0]   cr2;
  logic [DW-1:0]        mi2;
  logic [2:0]           nneg2;
  word_t                pt2;

  // Stage 3: sums.
  logic                 v3;
  logic [1:0]           row3;
  logic [SW-1:0]        s3;
  logic [SW-1:0]        pos3;
  logic [SW-1:0]        ng3;
  logic [2:0][SW-1:0]   cr3;
  logic [DW-1:0]        mi3;
  logic [2:0]           nneg3;
  word_t                pt3;

  // Stage 4: signed dot product as sign and magnitude.
  logic                 v4;
  logic [1:0]           row4;
  logic [SW-1:0]        s4;
  logic [SW-1:0]        dmag4;
  logic                 dneg4;
  logic                 zero4;
  logic [2:0][SW-1:0]   cr4;
  logic [DW-1:0]        mi4;
  logic [2:0]           nneg4;
  word_t                pt4;

  // Stage 5: translation dividend as two partial products.
  logic                 v5;
  logic [1:0]           row5;
  logic [SW-1:0]        s5;
  logic [SW-1:0]        plo5;
  logic [SW-1:0]        phi5;
  logic                 dneg5;
  logic                 zero5;
  logic [2:0][SW-1:0]   cr5;
  logic [2:0]           nneg5;
  word_t                pt5;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
      out_valid <= v5;
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      nmag1[k] <= mag_of(normal[k]);
      pmag1[k] <= mag_of(point[k]);
      nneg1[k] <= normal[k][DW-1];
      pneg1[k] <= point[k][DW-1];
    end
    row1 <= row;
    pt1  <= point[row];

    for (int k = 0; k < 3; k++) begin
      sq2[k]  <= SW'(nmag1[k]) * SW'(nmag1[k]);
      dp2[k]  <= SW'(pmag1[k]) * SW'(nmag1[k]);
      dpn2[k] <= pneg1[k] ^ nneg1[k];
      cr2[k]  <= SW'(nmag1[row1]) * SW'(nmag1[k]);
    end
    mi2   <= nmag1[row1];
    row2  <= row1;
    nneg2 <= nneg1;
    pt2   <= pt1;

    s3    <= sq2[0] + sq2[1] + sq2[2];
    pos3  <= (dpn2[0] ? '0 : dp2[0]) + (dpn2[1] ? '0 : dp2[1]) + (dpn2[2] ? '0 : dp2[2]);
    ng3   <= (dpn2[0] ? dp2[0] : '0) + (dpn2[1] ? dp2[1] : '0) + (dpn2[2] ? dp2[2] : '0);
    cr3   <= cr2;
    mi3   <= mi2;
    row3  <= row2;
    nneg3 <= nneg2;
    pt3   <= pt2;

    dneg4 <= pos3 < ng3;
    dmag4 <= (pos3 >= ng3) ? (pos3 - ng3) : (ng3 - pos3);
    zero4 <= s3 == '0;
    s4    <= s3;
    cr4   <= cr3;
    mi4   <= mi3;
    row4  <= row3;
    nneg4 <= nneg3;
    pt4   <= pt3;

    plo5  <= SW'(dmag4[DW-1:0]) * SW'(mi4);
    phi5  <= SW'(dmag4[SW-1:DW]) * SW'(mi4);
    s5    <= s4;
    dneg5 <= dneg4;
    zero5 <= zero4;
    cr5   <= cr4;
    row5  <= row4;
    nneg5 <= nneg4;
    pt5   <= pt4;

    s <= s5;
    for (int j = 0; j < 3; j++) begin
      num[j] <= NW'(cr5[j]) << FRAC_BITS;
      // An off-diagonal entry is negative when the two normal components agree in sign.
      side.ent_neg[j] <= ~(nneg5[row5] ^ nneg5[j]);
    end
    num[OFF_LANE] <= {phi5, {DW{1'b0}}} + NW'(plo5);
    side.row     <= row5;
    side.last    <= row5 == LAST_ROW;
    side.zero    <= zero5;
    side.off_neg <= dneg5 ^ nneg5[row5];
    side.pt      <= pt5;
  end

endmodule

FILE: design/ppm_div.sv
module ppm_div import ppm_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  input  logic [SW-1:0]             s_in,
  input  logic [NLANE-1:0][NW-1:0]  num,
  input  side_t                     side_in,
  output logic                      out_valid,
  output logic [SW-1:0]             s_out,
  output logic [NLANE-1:0][QW-1:0]  quo,
  output logic [NLANE-1:0][SW-1:0]  rem,
  output side_t                     side_out
);

  // One quotient bit per stage, all lanes sharing the divisor.
  logic                      vld [QW];
  logic [SW-1:0]             dq  [QW];
  side_t                     sd  [QW];
  logic [NLANE-1:0][SW-1:0]  rq  [QW];
  logic [NLANE-1:0][QW-1:0]  wq  [QW];

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic                      pv;
    logic [SW-1:0]             ps;
    side_t                     psd;
    logic [NLANE-1:0][SW-1:0]  pr;
    logic [NLANE-1:0][QW-1:0]  pw;
    logic [NLANE-1:0][SW-1:0]  nr;
    logic [NLANE-1:0][QW-1:0]  nw;

    if (k == 0) begin : g_first
      assign pv  = in_valid;
      assign ps  = s_in;
      assign psd = side_in;
      for (genvar l = 0; l < NLANE; l++) begin : g_ld
        assign pr[l] = SW'(num[l][NW-1:QW]);
        assign pw[l] = num[l][QW-1:0];
      end
    end else begin : g_next
      assign pv  = vld[k-1];
      assign ps  = dq[k-1];
      assign psd = sd[k-1];
      assign pr  = rq[k-1];
      assign pw  = wq[k-1];
    end

    for (genvar l = 0; l < NLANE; l++) begin : g_lane
      logic [SW:0] t;
      logic        ge;
      assign t     = {pr[l], pw[l][QW-1]};
      assign ge    = t >= {1'b0, ps};
      assign nr[l] = ge ? SW'(t - {1'b0, ps}) : t[SW-1:0];
      assign nw[l] = {pw[l][QW-2:0], ge};
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else begin
        vld[k] <= pv;
      end
    end

    always_ff @(posedge clk) begin
      dq[k] <= ps;
      sd[k] <= psd;
      rq[k] <= nr;
      wq[k] <= nw;
    end
  end

  assign out_valid = vld[QW-1];
  assign s_out     = dq[QW-1];
  assign side_out  = sd[QW-1];
  assign quo       = wq[QW-1];
  assign rem       = rq[QW-1];

endmodule

FILE: design/ppm_out.sv
module ppm_out import ppm_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  input  logic [SW-1:0]             s,
  input  logic [NLANE-1:0][QW-1:0]  quo,
  input  logic [NLANE-1:0][SW-1:0]  rem,
  input  side_t                     side,
  output logic                      done,
  output logic [1:0]                row_index,
  output logic [DW-1:0]             col0,
  output logic [DW-1:0]             col1,
  output logic [DW-1:0]             col2,
  output logic [DW-1:0]             offset,
  output logic                      last_row,
  output logic                      zero_normal
);

  localparam logic [QW:0] ONE     = (QW+1)'(1) << FRAC_BITS;
  localparam logic [QW:0] NEG_LIM = (QW+1)'(1) << (DW-1);
  localparam logic [QW:0] POS_LIM = NEG_LIM - 1'b1;

  function automatic logic [DW-1:0] sat_field(input logic neg, input logic [QW:0] mag);
    logic [QW:0] m;
    if (neg) begin
      m = (mag > NEG_LIM) ? NEG_LIM : mag;
      return DW'(-m);
    end
    m = (mag > POS_LIM) ? POS_LIM : mag;
    return DW'(m);
  endfunction

  // Rounding stage: ties go away from zero.
  logic                      v1;
  side_t                     side1;
  logic [NLANE-1:0][QW:0]    qr1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1   <= 1'b0;
      done <= 1'b0;
    end else begin
      v1   <= in_valid;
      done <= v1;
    end
  end

  always_ff @(posedge clk) begin
    side1 <= side;
    for (int l = 0; l < NLANE; l++) begin
      qr1[l] <= {1'b0, quo[l]} + (QW+1)'({rem[l], 1'b0} >= {1'b0, s});
    end
  end

  logic [2:0][DW-1:0] ent;
  logic [DW-1:0]      off;

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      if (side1.zero) begin
        ent[j] = (j == int'(side1.row) && side1.row != LAST_ROW) ? DW'(ONE) : '0;
      end else if (j == int'(side1.row)) begin
        ent[j] = (qr1[j] >= ONE) ? '0 : DW'(ONE - qr1[j]);
      end else begin
        ent[j] = sat_field(side1.ent_neg[j], qr1[j]);
      end
    end
    off = side1.zero ? side1.pt : sat_field(side1.off_neg, qr1[OFF_LANE]);
  end

  always_ff @(posedge clk) begin
    row_index   <= side1.row;
    col0        <= ent[0];
    col1        <= ent[1];
    col2        <= ent[2];
    offset      <= off;
    last_row    <= side1.last;
    zero_normal <= side1.zero;
  end

endmodule

FILE: sim/tb_top.sv
module tb_top;
  import ppm_pkg::*;

  // One plane as it goes into the block.
  typedef struct {
    logic signed [31:0] px, py, pz;
    logic signed [31:0] nx, ny, nz;
  } plane_t;

  // One matrix row as it comes out of the block.
  typedef struct {
    logic [1:0]         row;
    logic signed [31:0] c0, c1, c2;
    logic signed [31:0] off;
    logic               last;
    logic               zero;
  } mrow_t;

  localparam int FRAC = 16;
  localparam longint CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 80;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic signed [31:0] point_x = '0, point_y = '0, point_z = '0;
  logic signed [31:0] normal_x = '0, normal_y = '0, normal_z = '0;
  logic done;
  logic [1:0] row_index;
  logic signed [31:0] col0, col1, col2, offset;
  logic last_row, zero_normal;

  plane_t plane_q[$];
  mrow_t  rows_due[$];
  plane_t on_bus;
  int     planes_taken = 0;
  int     errors = 0;
  longint cycles = 0;

  plane_projection_matrix #(.FRAC_BITS(FRAC)) dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .point_x(point_x), .point_y(point_y), .point_z(point_z),
    .normal_x(normal_x), .normal_y(normal_y), .normal_z(normal_z),
    .done(done), .row_index(row_index), .col0(col0), .col1(col1), .col2(col2),
    .offset(offset), .last_row(last_row), .zero_normal(zero_normal)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Magnitude of a two's complement field; the sign is bit 31.
  function automatic logic [129:0] magnitude(input logic signed [31:0] v);
    logic [32:0] m;
    m = v[31] ? (33'd0 - {1'b1, v}) : {1'b0, v};
    return {97'd0, m};
  endfunction

  // Exact quotient rounded half away from zero (both operands nonnegative).
  function automatic logic [129:0] div_nearest(input logic [129:0] num,
                                               input logic [129:0] den);
    return ((num << 1) + den) / (den << 1);
  endfunction

  // Signed magnitude into a saturated 32-bit field.
  function automatic logic [31:0] clamp_field(input logic neg, input logic [129:0] q);
    logic [129:0] m;
    m = q;
    if (neg) begin
      if (m > 130'h8000_0000) m = 130'h8000_0000;
      return 32'd0 - m[31:0];
    end
    if (m > 130'h7FFF_FFFF) m = 130'h7FFF_FFFF;
    return m[31:0];
  endfunction

  // Works out the three rows of the projection matrix for a plane and
  // queues them as the results the block owes for that transaction.
  function automatic void project_plane(input plane_t p);
    logic [129:0] nm[3], pm[3];
    logic         nneg[3], pneg[3];
    logic [129:0] sq, pos, negs, dot, q;
    logic [129:0] one;
    logic [31:0]  ent[3];
    logic         dneg;
    mrow_t        r;
    nm[0] = magnitude(p.nx); nm[1] = magnitude(p.ny); nm[2] = magnitude(p.nz);
    pm[0] = magnitude(p.px); pm[1] = magnitude(p.py); pm[2] = magnitude(p.pz);
    nneg[0] = p.nx[31]; nneg[1] = p.ny[31]; nneg[2] = p.nz[31];
    pneg[0] = p.px[31]; pneg[1] = p.py[31]; pneg[2] = p.pz[31];
    one = 130'd1 << FRAC;
    sq = 0; pos = 0; negs = 0;
    for (int i = 0; i < 3; i++) begin
      sq += nm[i] * nm[i];
      if (pneg[i] != nneg[i]) negs += pm[i] * nm[i];
      else pos += pm[i] * nm[i];
    end
    dneg = negs > pos;
    dot = dneg ? negs - pos : pos - negs;
    for (int i = 0; i < 3; i++) begin
      r.row = i[1:0];
      r.last = (i == 2);
      if (sq == 0) begin
        // Zero normal: flattening along z and the point passed through.
        for (int j = 0; j < 3; j++) ent[j] = (i == j && i < 2) ? one[31:0] : 32'd0;
        r.off = (i == 0) ? p.px : (i == 1) ? p.py : p.pz;
        r.zero = 1'b1;
      end else begin
        for (int j = 0; j < 3; j++) begin
          q = div_nearest(nm[i] * nm[j] * one, sq);
          if (i == j) ent[j] = (q >= one) ? 32'd0 : (one[31:0] - q[31:0]);
          else ent[j] = clamp_field(nneg[i] == nneg[j], q);
        end
        q = div_nearest(dot * nm[i], sq);
        r.off = clamp_field(dneg != nneg[i], q);
        r.zero = 1'b0;
      end
      r.c0 = ent[0]; r.c1 = ent[1]; r.c2 = ent[2];
      rows_due.push_back(r);
    end
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("MISMATCH %s: got %h expected %h", what, got, want);
    errors++;
  endtask

  // Idling phases: none, sender idle often, none again (receiver cannot stall),
  // then sender idle now and then, each phase lasting 105 planes.
  function automatic logic sender_rests();
    int phase;
    phase = (planes_taken / 105) % 4;
    return (phase == 1 && ($urandom_range(99) < 57)) ||
           (phase == 3 && ($urandom_range(99) < 16));
  endfunction

  // Driver: a transaction completes at an edge where start is high and busy is
  // low; only then, or while start is low, is the next plane (or an idle cycle) put on the bus.
  always @(posedge clk) begin
    logic taken;
    if (rst) begin
      start <= 1'b0;
    end else begin
      taken = start && !busy;
      if (taken) begin
        project_plane(on_bus);
        planes_taken++;
      end
      if (!start || taken) begin
        if (plane_q.size() > 0 && !sender_rests()) begin
          on_bus = plane_q.pop_front();
          point_x <= on_bus.px; point_y <= on_bus.py; point_z <= on_bus.pz;
          normal_x <= on_bus.nx; normal_y <= on_bus.ny; normal_z <= on_bus.nz;
          start <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: every strobed row is checked against the oldest owed row.
  always @(posedge clk) begin
    mrow_t w;
    if (!rst && done) begin
      if (rows_due.size() == 0) begin
        report_mismatch("unexpected row", 32'(row_index), 32'd0);
      end else begin
        w = rows_due.pop_front();
        if (row_index !== w.row) report_mismatch("row_index", 32'(row_index), 32'(w.row));
        if (col0 !== w.c0) report_mismatch("col0", col0, w.c0);
        if (col1 !== w.c1) report_mismatch("col1", col1, w.c1);
        if (col2 !== w.c2) report_mismatch("col2", col2, w.c2);
        if (offset !== w.off) report_mismatch("offset", offset, w.off);
        if (last_row !== w.last) report_mismatch("last_row", 32'(last_row), 32'(w.last));
        if (zero_normal !== w.zero)
          report_mismatch("zero_normal", 32'(zero_normal), 32'(w.zero));
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic plane_t mk(input logic [31:0] a, b, c, d, e, f);
    plane_t p;
    p.px = a; p.py = b; p.pz = c; p.nx = d; p.ny = e; p.nz = f;
    return p;
  endfunction

  // Random coordinate: full range, small values, a bare extreme, or zero or 1 << 16.
  function automatic logic [31:0] rnd_coord();
    case ($urandom_range(5))
      0, 1: return $urandom;
      2, 3: return $signed($urandom_range(32'h0008_0000)) - 32'sh0004_0000;
      4: return $urandom_range(1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
      default: return $urandom_range(1) ? 32'd0 : 32'h0001_0000;
    endcase
  endfunction

  initial begin
    plane_t p;
    // Directed planes.
    plane_q.push_back(mk(0, 0, 0, 0, 0, 0));
    plane_q.push_back(mk(32'h0001_0000, 32'hFFFE_0000, 32'h0003_0000, 0, 0, 0));
    plane_q.push_back(mk(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 0, 0, 0));
    plane_q.push_back(mk(32'h0001_0000, 32'h0002_0000, 32'h0005_0000, 0, 0, 32'h0001_0000));
    plane_q.push_back(mk(32'h0001_0000, 32'h0002_0000, 32'h0005_0000, 0, 0, 32'hFFFF_0000));
    plane_q.push_back(mk(32'h0003_0000, 32'h0002_0000, 0, 32'h0001_0000, 0, 0));
    plane_q.push_back(mk(0, 32'h0004_0000, 0, 0, 32'h8000_0000, 0));
    // Point on a plane through the origin: p . n is zero.
    plane_q.push_back(mk(32'h0001_0000, 32'hFFFF_0000, 0,
                         32'h0001_0000, 32'h0001_0000, 32'h0001_0000));
    plane_q.push_back(mk(0, 0, 0, 32'h0002_0000, 32'hFFFD_0000, 32'h0007_0000));
    plane_q.push_back(mk(32'h0001_0000, 32'h0001_0000, 32'h0001_0000,
                         32'h0001_0000, 32'h0001_0000, 32'h0001_0000));
    // Extreme coordinates and normals.
    plane_q.push_back(mk(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                         32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
    plane_q.push_back(mk(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                         32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
    plane_q.push_back(mk(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                         32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
    plane_q.push_back(mk(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                         32'h0000_0001, 32'h0000_0001, 32'h0000_0001));
    plane_q.push_back(mk(32'h7FFF_FFFF, 0, 0, 32'h0000_0001, 32'h7FFF_FFFF, 0));
    plane_q.push_back(mk(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                         32'hFFFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFF));
    plane_q.push_back(mk(32'h0000_8000, 0, 0, 32'h0000_0003, 0, 32'h0000_0001));
    for (int k = 0; k < 420; k++) begin
      p = mk(rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord());
      // Now and then a zero normal or a normal along one axis.
      case ($urandom_range(9))
        0: begin p.nx = 0; p.ny = 0; p.nz = 0; end
        1: begin p.nx = 0; p.ny = 0; end
        default: ;
      endcase
      plane_q.push_back(p);
    end
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    wait (plane_q.size() == 0 && !start);
    @(posedge clk);
    while (rows_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
